>>> hdl/unordered_list_table_engine_macros.svh
`ifndef UNORDERED_LIST_TABLE_ENGINE_MACROS_SVH
`define UNORDERED_LIST_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ULTE_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("list table engine check failed");

// Next-cycle implication, disabled while reset is high.
`define ULTE_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("list table engine sequencing check failed");

`endif

>>> hdl/ulte_pkg.sv
package ulte_pkg;

   localparam int FUNC_WIDTH   = 3;
   localparam int DATA_WIDTH   = 32;
   localparam int POS_WIDTH    = 11;
   localparam int STATUS_WIDTH = 3;
   localparam int INDEX_WIDTH  = 10;
   localparam int COUNT_WIDTH  = 11;

   typedef logic [FUNC_WIDTH-1:0]          func_type;
   typedef logic signed [DATA_WIDTH-1:0]   data_type;
   typedef logic [POS_WIDTH-1:0]           pos_type;
   typedef logic [STATUS_WIDTH-1:0]        status_type;
   typedef logic [INDEX_WIDTH-1:0]         index_type;
   typedef logic [COUNT_WIDTH-1:0]         count_type;

   localparam func_type FUNC_APPEND   = 3'd0;
   localparam func_type FUNC_FIND     = 3'd1;
   localparam func_type FUNC_REPLACE  = 3'd2;
   localparam func_type FUNC_DELETE   = 3'd3;
   localparam func_type FUNC_WRITE_AT = 3'd4;
   localparam func_type FUNC_MAX      = 3'd5;

   localparam status_type STATUS_OK        = 3'd0;
   localparam status_type STATUS_NOT_FOUND = 3'd1;
   localparam status_type STATUS_FULL      = 3'd2;
   localparam status_type STATUS_EMPTY     = 3'd3;
   localparam status_type STATUS_BAD_POS   = 3'd4;

   typedef struct packed {
      logic equal;
      logic greater;
   } cmp_result_type;

endpackage

>>> hdl/ulte_channels.sv
interface ulte_req_if;
   import ulte_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   data_type key_value;
   data_type new_value;
   pos_type  position;

   modport source (output valid, func, key_value, new_value, position, input ready);
   modport sink (input valid, func, key_value, new_value, position, output ready);
endinterface

interface ulte_rsp_if;
   import ulte_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   index_type  found_index;
   data_type   result_value;
   count_type  entry_count;

   modport source (output valid, status, found_index, result_value, entry_count, input ready);
   modport sink (input valid, status, found_index, result_value, entry_count, output ready);
endinterface

>>> hdl/unordered_list_table_engine.sv
// Channel   Direction  Contents
// req_chan  in         func, key_value, new_value, position
// rsp_chan  out        status, found_index, result_value, entry_count
//
// Append, write-at and unused codes are settled in the start state, which goes straight to the response.
// Find, replace and maximum read one stored entry per cycle through the single read port;
// a delete scans in the same way and then moves the later entries down.
// Reset clears the count and the sequencer only; the entry memory needs no clearing pass.
// The block takes one transaction at a time and holds its result until rsp_chan accepts it.
`include "unordered_list_table_engine_macros.svh"

module unordered_list_table_engine #(
   parameter int DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   ulte_req_if.sink   req_chan,
   ulte_rsp_if.source rsp_chan
);
   import ulte_pkg::*;

   localparam int ADDR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);
   localparam int CMP_WIDTH  = (CNT_WIDTH > POS_WIDTH) ? CNT_WIDTH : POS_WIDTH;
   localparam logic [CNT_WIDTH-1:0] DEPTH_COUNT = CNT_WIDTH'(DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [CNT_WIDTH-1:0]          count_ff, count_in;
   logic                          pend_ff, pend_in;
   func_type                      func_ff, func_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic signed [VALUE_WIDTH-1:0] new_ff, new_in;
   pos_type                       pos_ff, pos_in;
   logic [CNT_WIDTH-1:0]          issue_ff, issue_in;
   logic [ADDR_WIDTH-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [ADDR_WIDTH-1:0]         found_ff, found_in;
   logic signed [VALUE_WIDTH-1:0] max_ff, max_in;
   status_type                    status_ff, status_in;

   logic                          wr_en;
   logic [ADDR_WIDTH-1:0]         wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;
   logic                          rd_en;
   logic [ADDR_WIDTH-1:0]         rd_addr;
   logic signed [VALUE_WIDTH-1:0] rd_data;
   logic signed [VALUE_WIDTH-1:0] cmp_rhs;
   cmp_result_type                cmp_res;
   logic                          issue_ok;
   logic [CMP_WIDTH-1:0]          pos_ext;
   logic [CMP_WIDTH-1:0]          count_ext;
   logic [CNT_WIDTH-1:0]          next_idx;
   logic [CNT_WIDTH-1:0]          count_inc;
   logic                          shift_write;
   logic                          append_go;

   ulte_store #(
      .DEPTH(DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   ulte_cmp #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_cmp (
      .lhs(rd_data),
      .rhs(cmp_rhs),
      .result(cmp_res)
   );

   assign issue_ok  = issue_ff < count_ff;
   assign rd_addr   = issue_ff[ADDR_WIDTH-1:0];
   assign cmp_rhs   = (func_ff == FUNC_MAX) ? max_ff : key_ff;
   assign pos_ext   = CMP_WIDTH'(pos_ff);
   assign count_ext = CMP_WIDTH'(count_ff);
   assign next_idx  = CNT_WIDTH'(cmp_idx_ff) + CNT_WIDTH'(1);
   assign count_inc = count_ff + CNT_WIDTH'(1);

   assign shift_write = (state_ff == ST_SHIFT) && pend_ff;
   assign append_go   = (state_ff == ST_START) && (func_ff == FUNC_APPEND)
                        && (count_ff < DEPTH_COUNT);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      new_in     = new_ff;
      pos_in     = pos_ff;
      issue_in   = issue_ff;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      max_in     = max_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in   = req_chan.func;
               key_in    = VALUE_WIDTH'(req_chan.key_value);
               new_in    = VALUE_WIDTH'(req_chan.new_value);
               pos_in    = req_chan.position;
               status_in = STATUS_OK;
               found_in  = '0;
               state_in  = ST_START;
            end
         end
         ST_START: begin
            issue_in = '0;
            pend_in  = 1'b0;
            state_in = ST_RESP;
            unique case (func_ff)
               FUNC_APPEND: begin
                  if (count_ff >= DEPTH_COUNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[ADDR_WIDTH-1:0];
                     wr_data  = key_ff;
                     count_in = count_inc;
                  end
               end
               FUNC_FIND, FUNC_REPLACE, FUNC_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NOT_FOUND;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               FUNC_WRITE_AT: begin
                  priority if (pos_ext < count_ext) begin
                     wr_en   = 1'b1;
                     wr_addr = pos_ext[ADDR_WIDTH-1:0];
                     wr_data = new_ff;
                  end else if (pos_ext > count_ext) begin
                     status_in = STATUS_BAD_POS;
                  end else begin
                     status_in = STATUS_OK;
                  end
               end
               FUNC_MAX: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
               default: begin
                  status_in = STATUS_OK;
               end
            endcase
         end
         ST_SCAN: begin
            rd_en      = issue_ok;
            issue_in   = issue_ok ? issue_ff + CNT_WIDTH'(1) : issue_ff;
            pend_in    = issue_ok;
            cmp_idx_in = rd_addr;
            if (pend_ff && func_ff == FUNC_MAX) begin
               if (cmp_idx_ff == '0 || cmp_res.greater) begin
                  max_in = rd_data;
               end
            end
            priority if (pend_ff && func_ff != FUNC_MAX && cmp_res.equal) begin
               found_in = cmp_idx_ff;
               state_in = ST_RESP;
               if (func_ff == FUNC_REPLACE) begin
                  wr_en   = 1'b1;
                  wr_addr = cmp_idx_ff;
                  wr_data = new_ff;
               end else if (func_ff == FUNC_DELETE) begin
                  if (next_idx < count_ff) begin
                     state_in = ST_SHIFT;
                     issue_in = next_idx;
                     pend_in  = 1'b0;
                  end else begin
                     count_in = count_ff - CNT_WIDTH'(1);
                  end
               end
            end else if (!issue_ok && !pend_ff) begin
               status_in = (func_ff == FUNC_MAX) ? STATUS_OK : STATUS_NOT_FOUND;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SHIFT: begin
            rd_en      = issue_ok;
            issue_in   = issue_ok ? issue_ff + CNT_WIDTH'(1) : issue_ff;
            pend_in    = issue_ok;
            cmp_idx_in = rd_addr;
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff - ADDR_WIDTH'(1);
               wr_data = rd_data;
            end
            if (!issue_ok && !pend_ff) begin
               count_in = count_ff - CNT_WIDTH'(1);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      key_ff     <= key_in;
      new_ff     <= new_in;
      pos_ff     <= pos_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      max_ff     <= max_in;
      status_ff  <= status_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_RESP);
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.found_index  = INDEX_WIDTH'(found_ff);
   assign rsp_chan.result_value = (func_ff == FUNC_MAX && status_ff == STATUS_OK)
                                  ? DATA_WIDTH'(max_ff) : '0;
   assign rsp_chan.entry_count  = COUNT_WIDTH'(count_ff);

   `ULTE_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_COUNT)
   `ULTE_ASSERT_IMPLIES(a_one_at_a_time, clock, reset, req_chan.ready, !rsp_chan.valid)
   `ULTE_ASSERT_IMPLIES(a_scan_nonempty, clock, reset, state_ff == ST_SCAN, count_ff != '0)
   `ULTE_ASSERT_IMPLIES(a_shift_no_underflow, clock, reset, shift_write, cmp_idx_ff != '0)
   `ULTE_ASSERT_NEXT(a_append_grows, clock, reset, append_go, count_ff == $past(count_inc))

endmodule

>>> hdl/ulte_cmp.sv
module ulte_cmp #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic signed [VALUE_WIDTH-1:0] lhs,
   input  logic signed [VALUE_WIDTH-1:0] rhs,
   output ulte_pkg::cmp_result_type      result
);
   import ulte_pkg::*;

   assign result = cmp_result_type'{equal: (lhs == rhs), greater: (lhs > rhs)};

endmodule

>>> hdl/ulte_store.sv
module ulte_store #(
   parameter int DEPTH = 1024,
   parameter int VALUE_WIDTH = 32,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AddrWidth-1:0]          wr_addr,
   input  logic signed [VALUE_WIDTH-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [AddrWidth-1:0]          rd_addr,
   output logic signed [VALUE_WIDTH-1:0] rd_data
);

   logic signed [VALUE_WIDTH-1:0] mem_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/unordered_list_table_engine_tb.sv
module unordered_list_table_engine_tb;
   import ulte_pkg::*;

   localparam int LIST_DEPTH = 1024;
   localparam int QUIET_LIMIT = 20000;
   localparam int PRINT_LIMIT = 50;
   localparam int HOLD_CYCLES = 300;

   localparam func_type FUNC_SPARE_6 = 3'd6;
   localparam func_type FUNC_SPARE_7 = 3'd7;

   localparam data_type MOST_NEGATIVE = 32'h8000_0000;
   localparam data_type MOST_POSITIVE = 32'h7fff_ffff;

   typedef struct {
      func_type func;
      data_type key_value;
      data_type new_value;
      pos_type  position;
   } list_op_type;

   typedef struct {
      status_type status;
      index_type  found_index;
      data_type   result_value;
      count_type  entry_count;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ulte_req_if req_if ();
   ulte_rsp_if rsp_if ();

   unordered_list_table_engine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   data_type         mirror_entries [LIST_DEPTH];
   int               mirror_count = 0;
   list_op_type      pending_ops [$];
   list_outcome_type expected_outcomes [$];
   list_op_type      accepted_op;
   list_op_type      next_op;
   list_outcome_type oldest_outcome;
   int               send_idle_pct;
   int               recv_stall_pct;
   logic             rsp_hold;
   logic             hold_request = 1'b0;
   int               hold_cycles;
   int               error_count = 0;
   int               quiet_cycles;

   always #2 clock = ~clock;

   task automatic report_mismatch(input string detail);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $time, detail);
      end
   endtask

   task automatic apply_list_op(input list_op_type op);
      list_outcome_type res;
      int hit;
      int i;
      data_type peak;
      hit = -1;
      res.status = STATUS_OK;
      res.found_index = '0;
      res.result_value = '0;
      for (i = 0; i < mirror_count; i++) begin
         if (hit < 0 && mirror_entries[i] == op.key_value) begin
            hit = i;
         end
      end
      case (op.func)
         FUNC_APPEND: begin
            if (mirror_count >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               mirror_entries[mirror_count] = op.key_value;
               mirror_count++;
            end
         end
         FUNC_FIND, FUNC_REPLACE, FUNC_DELETE: begin
            if (hit < 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               res.found_index = index_type'(hit);
               if (op.func == FUNC_REPLACE) begin
                  mirror_entries[hit] = op.new_value;
               end else if (op.func == FUNC_DELETE) begin
                  for (i = hit; i + 1 < mirror_count; i++) begin
                     mirror_entries[i] = mirror_entries[i + 1];
                  end
                  mirror_count--;
               end
            end
         end
         FUNC_WRITE_AT: begin
            if (int'(op.position) < mirror_count) begin
               mirror_entries[op.position] = op.new_value;
            end else if (int'(op.position) > mirror_count) begin
               res.status = STATUS_BAD_POS;
            end
         end
         FUNC_MAX: begin
            if (mirror_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               peak = mirror_entries[0];
               for (i = 1; i < mirror_count; i++) begin
                  if (mirror_entries[i] > peak) begin
                     peak = mirror_entries[i];
                  end
               end
               res.result_value = peak;
            end
         end
         default: begin
         end
      endcase
      res.entry_count = count_type'(mirror_count);
      expected_outcomes.push_back(res);
   endtask

   function automatic list_op_type make_op(input func_type func, input data_type key_value,
                                           input data_type new_value, input pos_type position);
      list_op_type op;
      op.func = func;
      op.key_value = key_value;
      op.new_value = new_value;
      op.position = position;
      return op;
   endfunction

   function automatic data_type pool_value();
      case ($urandom_range(7))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2: return 0;
         3: return -1;
         4: return 1;
         5: return 32'h0000_ffff;
         6: return 32'haaaa_aaaa;
         default: return 32'h1234_5678;
      endcase
   endfunction

   function automatic data_type pick_key();
      int r;
      r = $urandom_range(99);
      if (mirror_count > 0 && r < 55) begin
         return mirror_entries[$urandom_range(mirror_count - 1)];
      end
      if (r < 85) begin
         return pool_value();
      end
      return data_type'($urandom);
   endfunction

   function automatic list_op_type random_list_op();
      list_op_type op;
      int r;
      int p;
      r = $urandom_range(99);
      p = $urandom_range(99);
      op.key_value = pick_key();
      op.new_value = ($urandom_range(1) != 0) ? pool_value() : data_type'($urandom);
      if (p < 55) begin
         op.position = pos_type'($urandom_range(mirror_count));
      end else if (p < 70) begin
         op.position = pos_type'(mirror_count);
      end else if (p < 80) begin
         op.position = pos_type'(mirror_count + 1);
      end else begin
         op.position = pos_type'($urandom_range(2047));
      end
      if (r < 28) begin
         op.func = (mirror_count > 40) ? FUNC_DELETE : FUNC_APPEND;
      end else if (r < 43) begin
         op.func = FUNC_FIND;
      end else if (r < 57) begin
         op.func = FUNC_REPLACE;
      end else if (r < 75) begin
         op.func = FUNC_DELETE;
      end else if (r < 89) begin
         op.func = FUNC_WRITE_AT;
      end else if (r < 97) begin
         op.func = FUNC_MAX;
      end else begin
         op.func = ($urandom_range(1) != 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      end
      return op;
   endfunction

   task automatic queue_op(input list_op_type op);
      while (pending_ops.size() >= 2) @(negedge clock);
      pending_ops.push_back(op);
      @(negedge clock);
   endtask

   task automatic drain_all();
      while (pending_ops.size() != 0 || req_if.valid === 1'b1 || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            accepted_op.func = req_if.func;
            accepted_op.key_value = req_if.key_value;
            accepted_op.new_value = req_if.new_value;
            accepted_op.position = req_if.position;
            apply_list_op(accepted_op);
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = pending_ops.pop_front();
               req_if.valid <= 1'b1;
               req_if.func <= next_op.func;
               req_if.key_value <= next_op.key_value;
               req_if.new_value <= next_op.new_value;
               req_if.position <= next_op.position;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result transaction with no operation outstanding");
            end else begin
               oldest_outcome = expected_outcomes.pop_front();
               if (rsp_if.status !== oldest_outcome.status) begin
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_if.status, oldest_outcome.status));
               end
               if (rsp_if.found_index !== oldest_outcome.found_index) begin
                  report_mismatch($sformatf("found_index got %0d expected %0d",
                                            rsp_if.found_index, oldest_outcome.found_index));
               end
               if (rsp_if.result_value !== oldest_outcome.result_value) begin
                  report_mismatch($sformatf("result_value got %0h expected %0h",
                                            rsp_if.result_value, oldest_outcome.result_value));
               end
               if (rsp_if.entry_count !== oldest_outcome.entry_count) begin
                  report_mismatch($sformatf("entry_count got %0d expected %0d",
                                            rsp_if.entry_count, oldest_outcome.entry_count));
               end
            end
         end
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_hold <= (hold_cycles > 1);
      end else if (hold_request) begin
         hold_cycles <= HOLD_CYCLES;
         rsp_hold <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int n;
      int seg;
      data_type last_key;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list corner cases first, then a small list with duplicates and extremes.
      queue_op(make_op(FUNC_MAX, '0, '0, '0));
      queue_op(make_op(FUNC_FIND, 0, '0, '0));
      queue_op(make_op(FUNC_REPLACE, 0, 1, '0));
      queue_op(make_op(FUNC_DELETE, 0, '0, '0));
      queue_op(make_op(FUNC_WRITE_AT, '0, 5, 11'd0));
      queue_op(make_op(FUNC_WRITE_AT, '0, 5, 11'd1));
      queue_op(make_op(FUNC_WRITE_AT, -1, -1, 11'd2047));
      queue_op(make_op(FUNC_APPEND, MOST_NEGATIVE, '0, '0));
      queue_op(make_op(FUNC_APPEND, MOST_POSITIVE, '0, '0));
      queue_op(make_op(FUNC_APPEND, -1, '0, '0));
      queue_op(make_op(FUNC_APPEND, 0, '0, '0));
      queue_op(make_op(FUNC_APPEND, MOST_POSITIVE, '0, '0));
      queue_op(make_op(FUNC_FIND, MOST_POSITIVE, '0, '0));
      queue_op(make_op(FUNC_MAX, '0, '0, '0));
      queue_op(make_op(FUNC_REPLACE, MOST_POSITIVE, MOST_NEGATIVE, '0));
      queue_op(make_op(FUNC_FIND, MOST_POSITIVE, '0, '0));
      queue_op(make_op(FUNC_DELETE, MOST_NEGATIVE, '0, '0));
      queue_op(make_op(FUNC_WRITE_AT, '0, 32'h5555_5555, 11'd1));
      queue_op(make_op(FUNC_WRITE_AT, '0, 7, 11'd4));
      queue_op(make_op(FUNC_WRITE_AT, '0, 7, 11'd5));
      queue_op(make_op(FUNC_SPARE_6, -1, -1, 11'd2047));
      queue_op(make_op(FUNC_SPARE_7, 0, 0, 11'd0));
      queue_op(make_op(FUNC_MAX, '0, '0, '0));
      queue_op(make_op(FUNC_DELETE, MOST_POSITIVE, '0, '0));
      queue_op(make_op(FUNC_FIND, 32'h0bad_cafe, '0, '0));
      drain_all();

      for (seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 68; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 68; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (seg == 4) begin
            drain_all();
            hold_request = 1'b1;
            repeat (3) pending_ops.push_back(random_list_op());
            @(negedge clock);
            hold_request = 1'b0;
            while (rsp_hold) @(negedge clock);
            drain_all();
         end
         for (n = 0; n < 60; n++) begin
            queue_op(random_list_op());
         end
         if (seg == 1 || seg == 6) begin
            drain_all();
         end
      end

      drain_all();
      send_idle_pct = 14;
      recv_stall_pct = 14;
      for (n = 0; n < 60; n++) begin
         queue_op(make_op(FUNC_APPEND, data_type'($urandom), '0, '0));
      end
      queue_op(make_op(FUNC_MAX, '0, '0, '0));
      queue_op(make_op(FUNC_FIND, data_type'($urandom), '0, '0));
      queue_op(make_op(FUNC_WRITE_AT, '0, MOST_POSITIVE, pos_type'(LIST_DEPTH - 1)));
      queue_op(make_op(FUNC_WRITE_AT, '0, MOST_NEGATIVE, pos_type'(LIST_DEPTH)));
      queue_op(make_op(FUNC_WRITE_AT, '0, -1, pos_type'(LIST_DEPTH + 1)));
      queue_op(make_op(FUNC_MAX, '0, '0, '0));
      queue_op(make_op(FUNC_REPLACE, MOST_POSITIVE, 0, '0));
      drain_all();
      last_key = mirror_entries[mirror_count - 1];
      queue_op(make_op(FUNC_FIND, last_key, '0, '0));
      queue_op(make_op(FUNC_DELETE, last_key, '0, '0));
      queue_op(make_op(FUNC_APPEND, MOST_NEGATIVE, '0, '0));
      drain_all();
      queue_op(make_op(FUNC_DELETE, mirror_entries[0], '0, '0));
      queue_op(make_op(FUNC_MAX, '0, '0, '0));

      drain_all();
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/ulte_pkg.sv
hdl/ulte_channels.sv
hdl/ulte_cmp.sv
hdl/ulte_store.sv
hdl/unordered_list_table_engine.sv
tb/sv/unordered_list_table_engine_tb.sv
